// ===== src/weighted_graph_edge_store_assert.svh =====
// Assertion macros used by the checker file of the edge store.
`ifndef WEIGHTED_GRAPH_EDGE_STORE_ASSERT_SVH
`define WEIGHTED_GRAPH_EDGE_STORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define WGS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("edge store assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define WGS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("edge store assertion failed");

`endif

// ===== src/wgs_pkg.sv =====
// Shared types, constants and the starting-graph lookup of the edge store.
`default_nettype none

package wgs_pkg;

  localparam int NumVerticesDefault = 6;
  localparam int NumStartEdges      = 8;
  localparam int CmdQueueDepth      = 2;
  localparam int ResQueueDepth      = 2;

  // Input command codes
  localparam logic CmdList = 1'b0;
  localparam logic CmdSet  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOVERTEX = 2'd1,
    ST_NOEDGE   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // Classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_QUERY,
    OP_UPDATE,
    OP_BADVERTEX
  } op_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_QSCAN,
    BK_QFIN,
    BK_URD,
    BK_UEV,
    BK_UWR2
  } back_state_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] vertex_a;
    logic [3:0] vertex_b;
    logic [7:0] weight;
  } cmd_t;

  typedef struct packed {
    logic [3:0] neighbour;
    logic [7:0] edge_weight;
    status_e    status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
    logic [7:0] w;
  } start_edge_t;

  localparam start_edge_t StartEdges [NumStartEdges] = '{
    '{a: 4'd1, b: 4'd2, w: 8'd1},
    '{a: 4'd1, b: 4'd3, w: 8'd1},
    '{a: 4'd1, b: 4'd4, w: 8'd1},
    '{a: 4'd1, b: 4'd6, w: 8'd2},
    '{a: 4'd2, b: 4'd3, w: 8'd1},
    '{a: 4'd3, b: 4'd5, w: 8'd4},
    '{a: 4'd5, b: 4'd6, w: 8'd3},
    '{a: 4'd5, b: 4'd5, w: 8'd4}
  };

  // Weight of edge a-b in the starting graph, 0 when absent
  function automatic logic [7:0] start_weight(logic [3:0] a, logic [3:0] b);
    logic [7:0] w;
    w = 8'd0;
    for (int i = 0; i < NumStartEdges; i++) begin
      if ((StartEdges[i].a == a && StartEdges[i].b == b) ||
          (StartEdges[i].a == b && StartEdges[i].b == a)) begin
        w = StartEdges[i].w;
      end
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/weighted_graph_edge_store.sv =====
// A bad-vertex transaction is answered from the idle state. An update passes through
// a read state, an evaluate state and a second-write state; the sequencer takes no new
// command until the current one is through. A query scans its row one table read a cycle
// on the single read port, but can stall while the result queue is full; an update does
// a read, then two writes, and the removal of an absent edge a read only.
// Reset: queues empty; the table reverts at once to the starting graph via valid bits.
`default_nettype none

module weighted_graph_edge_store import wgs_pkg::*; #(
  parameter int NumVertices = NumVerticesDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic       cmd_i,
  input  wire logic [3:0] vertex_a_i,
  input  wire logic [3:0] vertex_b_i,
  input  wire logic [7:0] weight_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [3:0]      neighbour_o,
  output logic [7:0]      edge_weight_o,
  output logic [1:0]      status_o,
  output logic            last_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full;

  wgs_front #(
    .NumVertices (NumVertices)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .cmd_i       (cmd_i),
    .vertex_a_i  (vertex_a_i),
    .vertex_b_i  (vertex_b_i),
    .weight_i    (weight_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  wgs_back #(
    .NumVertices (NumVertices)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // Result queue decouples the sequencer from the consumer
  wgs_fifo #(
    .Width ($bits(res_t)),
    .Depth (ResQueueDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign neighbour_o   = res_out.neighbour;
  assign edge_weight_o = res_out.edge_weight;
  assign status_o      = res_out.status;
  assign last_o        = res_out.last;

endmodule

`default_nettype wire

// ===== src/wgs_fifo.sv =====
// Small first-in first-out queue with flop storage.
`default_nettype none

module wgs_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/wgs_front.sv =====
// Front end: checks vertex numbers, classifies each transaction and queues it.
`default_nettype none

module wgs_front import wgs_pkg::*; #(
  parameter int NumVertices = NumVerticesDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output logic            full_o,
  input  wire logic       cmd_i,
  input  wire logic [3:0] vertex_a_i,
  input  wire logic [3:0] vertex_b_i,
  input  wire logic [7:0] weight_i,
  output cmd_t            cmd_o,
  output logic            cmd_valid_o,
  input  wire logic       cmd_pop_i
);

  cmd_t cls;
  logic a_ok, b_ok, q_empty;

  assign a_ok = (vertex_a_i != 4'd0) && (vertex_a_i <= 4'(NumVertices));
  assign b_ok = (vertex_b_i != 4'd0) && (vertex_b_i <= 4'(NumVertices));

  // Classification: bad vertex numbers are settled here
  always_comb begin
    cls.vertex_a = vertex_a_i;
    cls.vertex_b = vertex_b_i;
    cls.weight   = weight_i;
    case (cmd_i)
      CmdList: cls.op = a_ok ? OP_QUERY : OP_BADVERTEX;
      CmdSet:  cls.op = (a_ok && b_ok) ? OP_UPDATE : OP_BADVERTEX;
      default: cls.op = OP_BADVERTEX;
    endcase
  end

  wgs_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CmdQueueDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cls),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (q_empty)
  );

  assign cmd_valid_o = !q_empty;

endmodule

`default_nettype wire

// ===== src/wgs_back.sv =====
// Back end: weight table memory and the sequencer that runs queries and updates.
`default_nettype none

module wgs_back import wgs_pkg::*; #(
  parameter int NumVertices = NumVerticesDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t cmd_i,
  input  wire logic cmd_valid_i,
  output logic      cmd_pop_o,
  output res_t      res_o,
  output logic      res_push_o,
  input  wire logic res_full_i
);

  localparam int Depth = NumVertices * NumVertices;
  localparam int AddrW = $clog2(Depth);

  // Row-major table address of entry a-b
  function automatic logic [AddrW-1:0] addr_of(logic [3:0] a, logic [3:0] b);
    logic [7:0] row;
    row = 8'(a - 4'd1) * 8'(NumVertices);
    return AddrW'(row + 8'(b - 4'd1));
  endfunction

  back_state_e state_q, state_d;
  cmd_t        cur_q, cur_d;
  logic [4:0]  rd_v_q, rd_v_d;
  logic [3:0]  ev_v_q, ev_v_d;
  logic        ev_vld_q, ev_vld_d;
  logic [3:0]  pend_v_q, pend_v_d;
  logic [7:0]  pend_w_q, pend_w_d;
  logic        pend_vld_q, pend_vld_d;

  logic [7:0]       mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [7:0]       rd_data_q, rd_init_q;
  logic             rd_valid_q;
  logic [7:0]       ew;

  logic       rd_en, we;
  logic [3:0] ra, rb, wa, wb;
  logic [AddrW-1:0] rd_addr, wr_addr;

  // Entries never written read as the starting graph
  assign ew      = rd_valid_q ? rd_data_q : rd_init_q;
  assign rd_addr = addr_of(ra, rb);
  assign wr_addr = addr_of(wa, wb);

  // Sequencer: next state and outputs
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    rd_v_d     = rd_v_q;
    ev_v_d     = ev_v_q;
    ev_vld_d   = ev_vld_q;
    pend_v_d   = pend_v_q;
    pend_w_d   = pend_w_q;
    pend_vld_d = pend_vld_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{neighbour: 4'd0, edge_weight: 8'd0, status: ST_OK, last: 1'b1};
    rd_en      = 1'b0;
    we         = 1'b0;
    ra         = cur_q.vertex_a;
    rb         = cur_q.vertex_b;
    wa         = cur_q.vertex_a;
    wb         = cur_q.vertex_b;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cur_d = cmd_i;
          case (cmd_i.op)
            OP_QUERY: begin
              cmd_pop_o  = 1'b1;
              rd_v_d     = 5'd1;
              ev_vld_d   = 1'b0;
              pend_vld_d = 1'b0;
              state_d    = BK_QSCAN;
            end
            OP_UPDATE: begin
              cmd_pop_o = 1'b1;
              state_d   = BK_URD;
            end
            default: begin
              if (!res_full_i) begin
                cmd_pop_o    = 1'b1;
                res_push_o   = 1'b1;
                res_o.status = ST_NOVERTEX;
              end
            end
          endcase
        end
      end
      BK_QSCAN: begin
        // Stall only when a found neighbor must displace a held one and the result queue is full
        if (!(ev_vld_q && ew != 8'd0 && pend_vld_q && res_full_i)) begin
          if (ev_vld_q && ew != 8'd0) begin
            if (pend_vld_q) begin
              res_push_o        = 1'b1;
              res_o.neighbour   = pend_v_q;
              res_o.edge_weight = pend_w_q;
              res_o.last        = 1'b0;
            end
            pend_v_d   = ev_v_q;
            pend_w_d   = ew;
            pend_vld_d = 1'b1;
          end
          if (rd_v_q <= 5'(NumVertices)) begin
            rd_en    = 1'b1;
            rb       = rd_v_q[3:0];
            ev_v_d   = rd_v_q[3:0];
            ev_vld_d = 1'b1;
            rd_v_d   = rd_v_q + 5'd1;
          end else begin
            ev_vld_d = 1'b0;
            if (!ev_vld_q) begin
              state_d = BK_QFIN;
            end
          end
        end
      end
      BK_QFIN: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (pend_vld_q) begin
            res_o.neighbour   = pend_v_q;
            res_o.edge_weight = pend_w_q;
          end else begin
            res_o.status = ST_EMPTY;
          end
          state_d = BK_IDLE;
        end
      end
      BK_URD: begin
        rd_en   = 1'b1;
        state_d = BK_UEV;
      end
      BK_UEV: begin
        if (!res_full_i) begin
          if (cur_q.weight == 8'd0 && ew == 8'd0) begin
            res_push_o   = 1'b1;
            res_o.status = ST_NOEDGE;
            state_d      = BK_IDLE;
          end else begin
            we      = 1'b1;
            state_d = BK_UWR2;
          end
        end
      end
      BK_UWR2: begin
        if (!res_full_i) begin
          we         = 1'b1;
          wa         = cur_q.vertex_b;
          wb         = cur_q.vertex_a;
          res_push_o = 1'b1;
          state_d    = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      ev_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      rd_v_q     <= 5'd0;
      valid_q    <= '0;
    end else begin
      state_q    <= state_d;
      ev_vld_q   <= ev_vld_d;
      pend_vld_q <= pend_vld_d;
      rd_v_q     <= rd_v_d;
      if (we) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    ev_v_q   <= ev_v_d;
    pend_v_q <= pend_v_d;
    pend_w_q <= pend_w_d;
  end

  // Weight table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= cur_q.weight;
    end
    if (rd_en) begin
      rd_data_q  <= mem_q[rd_addr];
      rd_valid_q <= valid_q[rd_addr];
      rd_init_q  <= start_weight(ra, rb);
    end
  end

endmodule

`default_nettype wire

// ===== src/wgs_checker.sv =====
// Port-level checker for the edge store and its bind to the top level.
`default_nettype none
`include "weighted_graph_edge_store_assert.svh"

module wgs_checker import wgs_pkg::*; #(
  parameter int NumVertices = NumVerticesDefault
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [3:0] neighbour_o,
  input wire logic [7:0] edge_weight_o,
  input wire logic [1:0] status_o,
  input wire logic       last_o
);

  // Error and empty results are single, final and carry no edge
  `WGS_ASSERT_IMP(a_err_fields, clk_i, rst_ni, !empty && status_o != ST_OK, last_o && neighbour_o == 4'd0 && edge_weight_o == 8'd0)

  // A listing entry that is not final names a real edge
  `WGS_ASSERT_IMP(a_list_entry, clk_i, rst_ni, !empty && status_o == ST_OK && !last_o, neighbour_o != 4'd0 && edge_weight_o != 8'd0)

  // Neighbors never exceed the vertex count
  `WGS_ASSERT_IMP(a_nb_range, clk_i, rst_ni, !empty, neighbour_o <= 4'(NumVertices))

  // A waiting result holds until taken
  `WGS_ASSERT_NXT(a_res_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(neighbour_o) && $stable(edge_weight_o) && $stable(status_o) && $stable(last_o))

endmodule

bind weighted_graph_edge_store wgs_checker #(.NumVertices(NumVertices)) u_wgs_checker (.*);

`default_nettype wire
